@@ rtl/core/battery_runtime_estimator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the battery runtime estimator
// Shared shorthand for clocked assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_RUNTIME_ESTIMATOR_UNIT_ASSERT_SVH
`define BATTERY_RUNTIME_ESTIMATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BRE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("battery runtime estimator: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("battery runtime estimator: next-cycle check failed");

`endif

@@ rtl/core/bre_pkg.sv @@
// ----------------------------------------------------------------------------
// bre_pkg
// Types, codes and constants of the battery runtime estimator.
// ----------------------------------------------------------------------------
package bre_pkg;

    localparam int RATE_W      = 20;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 10;
    localparam int DIV_STEP_W  = 5;
    localparam int MIN_STEPS_N = 6;
    localparam int PCT_STEPS_N = 7;
    localparam int MIN_V_W     = RATE_W + MIN_STEPS_N;
    localparam int PCT_V_W     = RATE_W + PCT_STEPS_N;

    localparam logic [DIV_STEP_W-1:0] WIDE_STEPS = DIV_STEP_W'(RATE_W);
    localparam logic [DIV_STEP_W-1:0] MIN_STEPS  = DIV_STEP_W'(MIN_STEPS_N);
    localparam logic [DIV_STEP_W-1:0] PCT_STEPS  = DIV_STEP_W'(PCT_STEPS_N);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MINUTES    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIDE_WHEN_ABSENT = 1'd1;
    localparam logic [CFG_DATA_W-1:0] ALARM_MIN_RESET     = 10'd10;

    // Status codes.
    localparam logic [2:0] STATUS_DISCHARGING  = 3'd0;
    localparam logic [2:0] STATUS_CHARGING     = 3'd1;
    localparam logic [2:0] STATUS_CHARGED      = 3'd2;
    localparam logic [2:0] STATUS_NOT_CHARGING = 3'd3;
    localparam logic [2:0] STATUS_ABSENT       = 3'd4;

    // Percent thresholds and limits.
    localparam logic [6:0] PCT_FULL = 7'd100;
    localparam logic [6:0] PCT_T95  = 7'd95;
    localparam logic [6:0] PCT_T75  = 7'd75;
    localparam logic [6:0] PCT_T50  = 7'd50;
    localparam logic [6:0] PCT_T25  = 7'd25;
    localparam logic [6:0] PCT_T15  = 7'd15;
    localparam logic [6:0] PCT_T8   = 7'd8;
    localparam logic [5:0] MINUTE_MAX = 6'd59;

    // Icon indexes.
    localparam logic [3:0] ICON_EMPTY  = 4'd0;
    localparam logic [3:0] ICON_CHG_LO = 4'd7;
    localparam logic [3:0] ICON_HIDDEN = 4'd13;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RING_RD,
        ST_RING_WR,
        ST_AVG_LD,
        ST_AVG_DIV,
        ST_TIME_LD,
        ST_TIME_DIV,
        ST_MIN_LD,
        ST_MIN_DIV,
        ST_PCT_LD,
        ST_PCT_DIV,
        ST_FINISH
    } bre_state_t;

    // Input payload, first field in the highest bits.
    typedef struct packed {
        logic [2:0]        pad;
        logic              charging;
        logic [RATE_W-1:0] total_rate;
        logic [RATE_W-1:0] total_charge;
        logic [RATE_W-1:0] total_capacity;
    } bre_in_t;

    // Result payload, first field in the highest bits.
    typedef struct packed {
        logic [2:0]        pad;
        logic [RATE_W-1:0] average_rate;
        logic [3:0]        icon_level;
        logic [2:0]        status;
        logic              alarm;
        logic [5:0]        minutes;
        logic [RATE_W-1:0] hours;
        logic [6:0]        percent;
    } bre_out_t;

    function automatic logic [3:0] icon_of(input logic chg, input logic [6:0] pct);
        logic [3:0] lvl;
        if (pct >= PCT_T95) lvl = 4'd6;
        else if (pct >= PCT_T75) lvl = 4'd5;
        else if (pct >= PCT_T50) lvl = 4'd4;
        else if (pct >= PCT_T25) lvl = 4'd3;
        else if (pct >= PCT_T15) lvl = 4'd2;
        else if (pct >= PCT_T8) lvl = 4'd1;
        else lvl = ICON_EMPTY;
        // Charging icons sit six above the discharging ones and have no 8 percent step.
        if (chg) lvl = (lvl == ICON_EMPTY) ? ICON_CHG_LO : lvl + 4'd6;
        return lvl;
    endfunction

endpackage

@@ rtl/core/battery_runtime_estimator_unit.sv @@
// ----------------------------------------------------------------------------
// battery_runtime_estimator_unit
// Each transaction with a battery present pushes its rate into a ring of the
// last SAMPLE_DEPTH samples (emptied when the charging flag flips) and returns
// percent, time to full or empty, alarm, status, icon and the averaged rate.
// All divisions go through one shared restoring divider that produces one
// quotient bit per cycle, and that divider sets the rate: an item with a
// battery present passes through ring read and write, then four divider
// passes of 20, 20, 6 and 7 quotient bits, each after its own load state,
// then a result state that waits for the output register to be free; an
// item without a battery goes straight to the result state. A new item is
// taken only back in idle. A result waits in the output register while the
// next item is computed. The rate ring needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module battery_runtime_estimator_unit #(
    parameter int SAMPLE_DEPTH = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // total_capacity[19:0], total_charge[39:20], total_rate[59:40],
    // charging[60], zero[63:61]
    input  logic [bre_pkg::IN_TDATA_W-1:0]  s_tdata,
    // battery_present[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // percent[6:0], hours[26:7], minutes[32:27], alarm[33], status[36:34],
    // icon_level[40:37], average_rate[60:41], zero[63:61]
    output logic [bre_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bre_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bre_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bre_pkg::*;

    localparam int SLOT_W = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W  = $clog2(2 * SAMPLE_DEPTH);
    localparam int SUM_W  = RATE_W + SLOT_W;
    localparam logic [CNT_W:0] DEPTH_X = (CNT_W + 1)'(SAMPLE_DEPTH);
    localparam logic [CNT_W:0] WRAP_X  = (CNT_W + 1)'(2 * SAMPLE_DEPTH);

    bre_state_t state_reg, state_next;
    bre_in_t    in_word;
    bre_out_t   res;
    logic       in_fire;
    logic       div_run;
    logic       out_free;
    logic       out_load;

    // Configuration.
    logic [CFG_DATA_W-1:0] alarm_min_reg;
    logic                  hide_reg;

    // Captured item.
    logic              present_reg;
    logic              charging_reg;
    logic [RATE_W-1:0] cap_reg;
    logic [RATE_W-1:0] charge_reg;
    logic [RATE_W-1:0] rate_reg;

    // Rate history.
    logic [RATE_W-1:0] ring_mem [SAMPLE_DEPTH];
    logic [RATE_W-1:0] ring_rd_reg;
    logic              last_chg_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              chg_flip;
    logic [CNT_W-1:0]  count_eff;
    logic [CNT_W:0]    slot_wide;
    logic [SLOT_W-1:0] slot;
    logic              full;
    logic [CNT_W:0]    cnt_inc;
    logic [CNT_W:0]    cnt_wrap;
    logic [CNT_W-1:0]  count_next;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W:0]    held;

    // Shared divider.
    logic [RATE_W-1:0]     rem_reg;
    logic [RATE_W-1:0]     dsr_reg;
    logic [RATE_W-1:0]     quo_reg;
    logic [RATE_W-1:0]     dvs_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [RATE_W:0]       div_ext;
    logic [RATE_W+1:0]     div_diff;
    logic                  div_take;
    logic [RATE_W-1:0]     rem_step;

    // Intermediate results.
    logic [RATE_W-1:0] avg_reg;
    logic [RATE_W-1:0] hours_reg;
    logic [5:0]        mins_reg;
    logic [RATE_W-1:0] time_x;
    logic [MIN_V_W-1:0] min_v;
    logic [PCT_V_W-1:0] pct_v;
    logic              avg_nz;
    logic [6:0]        pct_res;
    logic [10:0]       alarm_time;

    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tvalid_reg;

    assign in_word   = bre_in_t'(s_tdata);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // ------------------------------------------------------------------
    // Ring bookkeeping
    // ------------------------------------------------------------------
    assign chg_flip  = last_chg_reg != charging_reg;
    assign count_eff = (state_reg == ST_RING_RD && chg_flip) ? '0 : count_reg;
    assign slot_wide = ({1'b0, count_eff} >= DEPTH_X) ? ({1'b0, count_eff} - DEPTH_X)
                                                      : {1'b0, count_eff};
    assign slot      = slot_wide[SLOT_W-1:0];
    assign full      = {1'b0, count_reg} >= DEPTH_X;
    assign cnt_inc   = {1'b0, count_reg} + (CNT_W + 1)'(1);
    assign cnt_wrap  = (cnt_inc >= WRAP_X) ? (cnt_inc - DEPTH_X) : cnt_inc;
    assign count_next = cnt_wrap[CNT_W-1:0];
    assign sum_next  = sum_reg - (full ? SUM_W'(ring_rd_reg) : '0) + SUM_W'(rate_reg);
    assign held      = full ? DEPTH_X : {1'b0, count_reg};

    // ------------------------------------------------------------------
    // Divider step: one quotient bit per cycle
    // ------------------------------------------------------------------
    assign div_ext  = {rem_reg, dsr_reg[RATE_W-1]};
    assign div_diff = {1'b0, div_ext} - {2'b00, dvs_reg};
    assign div_take = !div_diff[RATE_W+1];
    assign rem_step = div_take ? div_diff[RATE_W-1:0] : div_ext[RATE_W-1:0];

    // Operand set-up for the later passes.
    assign time_x = charging_reg ? ((cap_reg > charge_reg) ? (cap_reg - charge_reg) : '0)
                                 : charge_reg;
    // 60 * remainder; the quotient of the minutes pass stays below 64.
    assign min_v  = MIN_V_W'({rem_reg, 6'b0}) - MIN_V_W'({rem_reg, 2'b0});
    // 100 * charge; the quotient stays below 128 whenever charge < capacity.
    assign pct_v  = PCT_V_W'({charge_reg, 6'b0}) + PCT_V_W'({charge_reg, 5'b0})
                  + PCT_V_W'({charge_reg, 2'b0});

    // ------------------------------------------------------------------
    // Result assembly
    // ------------------------------------------------------------------
    assign avg_nz     = avg_reg != '0;
    assign alarm_time = 11'({hours_reg[4:0], 6'b0}) - 11'({hours_reg[4:0], 2'b0})
                      + 11'(mins_reg);

    always_comb
    begin
        if (cap_reg == '0)
        begin
            pct_res = '0;
        end
        else if (charge_reg >= cap_reg)
        begin
            pct_res = PCT_FULL;
        end
        else
        begin
            pct_res = quo_reg[6:0];
        end
    end

    always_comb
    begin
        res = '0;
        if (!present_reg)
        begin
            res.status     = STATUS_ABSENT;
            res.icon_level = hide_reg ? ICON_HIDDEN : ICON_EMPTY;
        end
        else
        begin
            res.percent      = pct_res;
            res.average_rate = avg_reg;
            res.icon_level   = icon_of(charging_reg, pct_res);
            if (avg_nz)
            begin
                res.hours   = hours_reg;
                res.minutes = mins_reg;
            end
            if (charging_reg)
            begin
                if (avg_nz)
                begin
                    res.status = STATUS_CHARGING;
                end
                else if (charge_reg >= cap_reg)
                begin
                    res.status = STATUS_CHARGED;
                end
                else
                begin
                    res.status = STATUS_NOT_CHARGING;
                end
            end
            else
            begin
                res.status = STATUS_DISCHARGING;
                // More than 17 hours is always above any 10-bit minute limit.
                res.alarm  = avg_nz && (hours_reg[RATE_W-1:5] == '0)
                          && (alarm_time <= {1'b0, alarm_min_reg});
            end
        end
    end

    // ------------------------------------------------------------------
    // Control FSM
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = s_tuser ? ST_RING_RD : ST_FINISH;
                end
            end
            ST_RING_RD:  state_next = ST_RING_WR;
            ST_RING_WR:  state_next = ST_AVG_LD;
            ST_AVG_LD:   state_next = ST_AVG_DIV;
            ST_AVG_DIV:
            begin
                if (step_reg == DIV_STEP_W'(1))
                begin
                    state_next = ST_TIME_LD;
                end
            end
            ST_TIME_LD:  state_next = ST_TIME_DIV;
            ST_TIME_DIV:
            begin
                if (step_reg == DIV_STEP_W'(1))
                begin
                    state_next = ST_MIN_LD;
                end
            end
            ST_MIN_LD:   state_next = ST_MIN_DIV;
            ST_MIN_DIV:
            begin
                if (step_reg == DIV_STEP_W'(1))
                begin
                    state_next = ST_PCT_LD;
                end
            end
            ST_PCT_LD:   state_next = ST_PCT_DIV;
            ST_PCT_DIV:
            begin
                if (step_reg == DIV_STEP_W'(1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        div_run  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:     s_tready = 1'b1;
            ST_AVG_DIV,
            ST_TIME_DIV,
            ST_MIN_DIV,
            ST_PCT_DIV:  div_run  = 1'b1;
            ST_FINISH:   out_load = out_free;
            default:     s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alarm_min_reg <= ALARM_MIN_RESET;
            hide_reg      <= 1'b0;
            last_chg_reg  <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ALARM_MINUTES:    alarm_min_reg <= cfg_data;
                    CFG_HIDE_WHEN_ABSENT: hide_reg      <= cfg_data[0];
                    default:              hide_reg      <= hide_reg;
                endcase
            end
            // A change of the charging flag empties the ring.
            if (state_reg == ST_RING_RD && chg_flip)
            begin
                last_chg_reg <= charging_reg;
                count_reg    <= '0;
                sum_reg      <= '0;
            end
            if (state_reg == ST_RING_WR)
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Rate ring memory
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RING_WR)
        begin
            ring_mem[slot] <= rate_reg;
        end
        if (state_reg == ST_RING_RD)
        begin
            ring_rd_reg <= ring_mem[slot];
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            present_reg  <= s_tuser;
            charging_reg <= in_word.charging;
            cap_reg      <= in_word.total_capacity;
            charge_reg   <= in_word.total_charge;
            rate_reg     <= in_word.total_rate;
        end
        if (div_run)
        begin
            rem_reg  <= rem_step;
            dsr_reg  <= {dsr_reg[RATE_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[RATE_W-2:0], div_take};
            step_reg <= step_reg - DIV_STEP_W'(1);
        end
        case (state_reg)
            ST_AVG_LD:
            begin
                dvs_reg  <= RATE_W'(held);
                rem_reg  <= RATE_W'(sum_reg >> RATE_W);
                dsr_reg  <= sum_reg[RATE_W-1:0];
                step_reg <= WIDE_STEPS;
            end
            ST_TIME_LD:
            begin
                avg_reg  <= quo_reg;
                dvs_reg  <= quo_reg;
                rem_reg  <= '0;
                dsr_reg  <= time_x;
                step_reg <= WIDE_STEPS;
            end
            ST_MIN_LD:
            begin
                hours_reg <= quo_reg;
                rem_reg   <= min_v[MIN_V_W-1:MIN_STEPS_N];
                dsr_reg   <= {min_v[MIN_STEPS_N-1:0], {(RATE_W - MIN_STEPS_N){1'b0}}};
                step_reg  <= MIN_STEPS;
            end
            ST_PCT_LD:
            begin
                mins_reg <= quo_reg[5:0];
                dvs_reg  <= cap_reg;
                rem_reg  <= pct_v[PCT_V_W-1:PCT_STEPS_N];
                dsr_reg  <= {pct_v[PCT_STEPS_N-1:0], {(RATE_W - PCT_STEPS_N){1'b0}}};
                step_reg <= PCT_STEPS;
            end
            default:
            begin
                avg_reg <= avg_reg;
            end
        endcase
        if (out_load)
        begin
            m_tdata_reg <= res;
        end
    end

endmodule

@@ rtl/core/bre_checker.sv @@
// ----------------------------------------------------------------------------
// bre_checker
// Port-level checks of the battery runtime estimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "battery_runtime_estimator_unit_assert.svh"

module bre_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bre_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import bre_pkg::*;

    bre_out_t res;
    logic     out_in_range;
    logic     absent_clean;
    logic     alarm_ok;
    logic     in_fire;
    logic     out_stall;

    assign res = bre_out_t'(m_tdata);

    assign out_in_range = res.percent <= PCT_FULL && res.minutes <= MINUTE_MAX
                       && res.status <= STATUS_ABSENT && res.icon_level <= ICON_HIDDEN;
    assign absent_clean = res.percent == '0 && res.hours == '0 && res.minutes == '0
                       && !res.alarm && res.average_rate == '0;
    assign alarm_ok     = res.status == STATUS_DISCHARGING && res.average_rate != '0;
    assign in_fire      = s_tvalid && s_tready;
    assign out_stall    = m_tvalid && !m_tready;

    `BRE_ASSERT_IMPLY(a_out_range, clk, rst_n, m_tvalid, out_in_range)
    `BRE_ASSERT_IMPLY(a_absent_zero, clk, rst_n, m_tvalid && res.status == STATUS_ABSENT, absent_clean)
    `BRE_ASSERT_IMPLY(a_alarm_cause, clk, rst_n, m_tvalid && res.alarm, alarm_ok)
    `BRE_ASSERT_NEXT(a_one_item, clk, rst_n, in_fire, !s_tready)
    `BRE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_tvalid && $stable(m_tdata))

endmodule

bind battery_runtime_estimator_unit bre_checker u_bre_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Battery runtime estimator testbench
// Drives battery readings and register writes into the estimator over its
// stream and configuration channels. Both sides idle at random. A scoreboard
// predicts every estimate from its own copy of the rate ring and registers
// and checks each one, field by field, as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import bre_pkg::*;

    localparam int RING_DEPTH = 10;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    typedef struct {
        bit                present;
        logic [RATE_W-1:0] capacity;
        logic [RATE_W-1:0] charge;
        logic [RATE_W-1:0] rate;
        bit                charging;
    } battery_reading_t;

    // Predicts the estimate for each accepted reading and checks the block's output.
    class estimate_checker;
        logic [RATE_W-1:0] rate_hist [RING_DEPTH];
        longint unsigned   rate_total;
        int unsigned       held_count;
        bit                prev_charging;
        logic [9:0]        alarm_limit;
        bit                hide_icon;
        bre_out_t          expected_q [$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       alarms;
        int unsigned       absent_readings;
        int unsigned       status_hits [5];

        function new();
            rate_total    = 0;
            held_count    = 0;
            prev_charging = 1'b0;
            alarm_limit   = ALARM_MIN_RESET;
            hide_icon     = 1'b0;
            mismatches    = 0;
            checked       = 0;
            alarms        = 0;
            absent_readings = 0;
            foreach (status_hits[k]) status_hits[k] = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_ALARM_MINUTES)
                alarm_limit = val;
            else if (idx == CFG_HIDE_WHEN_ABSENT)
                hide_icon = val[0];
        endfunction

        // Icon level is the base icon plus the number of percent marks reached.
        function logic [3:0] icon_for(bit chg, longint unsigned pct);
            logic [6:0]  marks [6];
            int unsigned reached;
            marks = '{PCT_T95, PCT_T75, PCT_T50, PCT_T25, PCT_T15, PCT_T8};
            reached = 0;
            for (int k = 0; k < (chg ? 5 : 6); k++)
                if (pct >= marks[k]) reached++;
            return chg ? ICON_CHG_LO + 4'(reached) : ICON_EMPTY + 4'(reached);
        endfunction

        function void note_reading(battery_reading_t rd);
            bre_out_t        est;
            longint unsigned cap, chg, avg, pct, remain;
            int unsigned     slot;
            est = '0;
            if (!rd.present) begin
                est.status     = STATUS_ABSENT;
                est.icon_level = hide_icon ? ICON_HIDDEN : ICON_EMPTY;
                absent_readings++;
                expected_q.push_back(est);
                return;
            end
            // A change of the charging flag empties the ring.
            if (prev_charging != rd.charging) begin
                prev_charging = rd.charging;
                held_count    = 0;
                rate_total    = 0;
            end
            slot = held_count % RING_DEPTH;
            if (held_count >= RING_DEPTH)
                rate_total -= rate_hist[slot];
            rate_hist[slot] = rd.rate;
            rate_total += rd.rate;
            held_count++;
            if (held_count >= 2 * RING_DEPTH)
                held_count -= RING_DEPTH;
            avg = rate_total / ((held_count < RING_DEPTH) ? held_count : RING_DEPTH);

            cap = rd.capacity;
            chg = rd.charge;
            pct = (cap != 0) ? chg * 100 / cap : 0;
            if (pct > PCT_FULL)
                pct = PCT_FULL;
            if (rd.charging) begin
                if (avg != 0) begin
                    est.status = STATUS_CHARGING;
                    if (cap > chg) begin
                        remain      = cap - chg;
                        est.hours   = RATE_W'(remain / avg);
                        est.minutes = 6'((remain * 60 / avg) % 60);
                    end
                end else begin
                    est.status = (chg >= cap) ? STATUS_CHARGED : STATUS_NOT_CHARGING;
                end
            end else begin
                est.status = STATUS_DISCHARGING;
                if (avg != 0) begin
                    est.hours   = RATE_W'(chg / avg);
                    est.minutes = 6'((chg * 60 / avg) % 60);
                    est.alarm   = (chg * 60 / avg <= alarm_limit);
                end
            end
            est.percent      = 7'(pct);
            est.icon_level   = icon_for(rd.charging, pct);
            est.average_rate = RATE_W'(avg);
            expected_q.push_back(est);
        endfunction

        function string show(bre_out_t e);
            return $sformatf("pct=%0d h=%0d m=%0d alarm=%0d status=%0d icon=%0d avg=%0d",
                             e.percent, e.hours, e.minutes, e.alarm, e.status,
                             e.icon_level, e.average_rate);
        endfunction

        function void check_estimate(logic [OUT_TDATA_W-1:0] data);
            bre_out_t got, want;
            got = data;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: estimate with none expected: %s", $realtime, show(got));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            alarms += want.alarm;
            if (want.status <= STATUS_ABSENT)
                status_hits[want.status]++;
            if (got.percent !== want.percent || got.hours !== want.hours ||
                got.minutes !== want.minutes || got.alarm !== want.alarm ||
                got.status !== want.status || got.icon_level !== want.icon_level ||
                got.average_rate !== want.average_rate) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: estimate %0d mismatch\n  expected %s\n  actual   %s",
                             $realtime, checked, show(want), show(got));
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    estimate_checker sb = new();

    bit                run_charging;
    int unsigned       run_style;
    logic [RATE_W-1:0] run_base;
    int unsigned       readings_sent;
    int unsigned       settings_used;
    bit                held_off;

    battery_runtime_estimator_unit #(
        .SAMPLE_DEPTH(RING_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #50_000_000;
        $display("Timeout with %0d estimates still outstanding", sb.pending());
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_estimate(m_tdata);
    end

    // Output side: random ready stretches, plus one long hold-off that backs up the block.
    initial
    begin
        int unsigned r;
        m_tready = 1'b0;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && sb.checked >= 150) begin
                held_off = 1'b1;
                m_tready = 1'b0;
                repeat (600) @(negedge clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    m_tready = 1'b1;
                    repeat ($urandom_range(1, 100)) @(negedge clk);
                end else begin
                    m_tready = 1'b0;
                    if (r < 85)
                        repeat ($urandom_range(1, 8)) @(negedge clk);
                    else if (r < 97)
                        repeat ($urandom_range(9, 80)) @(negedge clk);
                    else
                        repeat ($urandom_range(81, 400)) @(negedge clk);
                end
            end
        end
    end

    function automatic logic [RATE_W-1:0] draw_value();
        int unsigned mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0:       return '0;
            1:       return RATE_MAX;
            2, 3:    return RATE_W'($urandom_range(1, 1000));
            4, 5, 6: return RATE_W'($urandom);
            default: return RATE_W'($urandom) & RATE_W'((1 << $urandom_range(1, RATE_W)) - 1);
        endcase
    endfunction

    // Readings come in runs of one charging flag with a rate profile per run.
    function automatic battery_reading_t next_reading();
        battery_reading_t rd;
        int unsigned      r;
        rd.present  = 1'b1;
        rd.capacity = draw_value();
        if ($urandom_range(0, 9) < 6)
            rd.charge = RATE_W'((longint'(rd.capacity) * $urandom_range(0, 110) / 100) > RATE_MAX
                                ? RATE_MAX
                                : longint'(rd.capacity) * $urandom_range(0, 110) / 100);
        else
            rd.charge = draw_value();
        r = $urandom_range(0, 99);
        if (r < 8) begin
            rd.present  = 1'b0;
            rd.rate     = RATE_W'($urandom);
            rd.charging = $urandom_range(0, 1);
            return rd;
        end
        if (r < 11 || $urandom_range(0, 19) == 0) begin
            // Noise flips the flag once; a new run also picks a new rate profile.
            run_charging = !run_charging;
            if (r >= 11) begin
                run_style = $urandom_range(0, 3);
                run_base  = draw_value();
            end
        end
        case (run_style)
            0:       rd.rate = '0;
            1:       rd.rate = RATE_W'($urandom_range(1, 2000));
            2:       rd.rate = draw_value();
            default: rd.rate = run_base ^ RATE_W'($urandom_range(0, 63));
        endcase
        rd.charging = run_charging;
        return rd;
    endfunction

    task automatic sender_gap();
        int unsigned r, n;
        r = $urandom_range(0, 99);
        if (r < 35)
            return;
        n = (r < 80) ? $urandom_range(1, 12) : (r < 95) ? $urandom_range(13, 90)
                                                       : $urandom_range(91, 400);
        s_tvalid = 1'b0;
        s_tdata  = {$urandom, $urandom};
        s_tuser  = $urandom_range(0, 1);
        repeat (n) @(negedge clk);
    endtask

    task automatic send_reading(battery_reading_t rd);
        bre_in_t pkt;
        pkt                = '0;
        pkt.total_capacity = rd.capacity;
        pkt.total_charge   = rd.charge;
        pkt.total_rate     = rd.rate;
        pkt.charging       = rd.charging;
        s_tvalid = 1'b1;
        s_tdata  = pkt;
        s_tuser  = rd.present;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_reading(rd);
        readings_sent++;
        @(negedge clk);
        sender_gap();
    endtask

    task automatic directed_reading(bit p, int unsigned cap, int unsigned chg,
                                    int unsigned rate, bit charging);
        battery_reading_t rd;
        rd.present  = p;
        rd.capacity = RATE_W'(cap);
        rd.charge   = RATE_W'(chg);
        rd.rate     = RATE_W'(rate);
        rd.charging = charging;
        send_reading(rd);
    endtask

    task automatic random_readings(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_reading(next_reading());
    endtask

    // Registers change only once the block has delivered every estimate and gone idle.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (70) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        int unsigned guard;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_ALARM_MINUTES;
        cfg_data      = '0;
        run_charging  = 1'b0;
        run_style     = 2;
        run_base      = '0;
        readings_sent = 0;
        settings_used = 1;
        @(posedge rst_n);
        @(negedge clk);

        // Directed readings under the reset register values.
        directed_reading(0, 0, 0, 0, 0);
        directed_reading(1, 0, 0, 0, 0);
        directed_reading(1, 100, 100, 0, 0);
        directed_reading(1, 100, 95, 600, 0);
        directed_reading(1, 100, 74, 600, 0);
        directed_reading(1, 100, 50, 600, 0);
        directed_reading(1, 100, 24, 600, 0);
        directed_reading(1, 100, 15, 600, 0);
        directed_reading(1, 100, 8, 600, 0);
        directed_reading(1, 100, 7, 600, 0);
        directed_reading(1, 1000, 1, RATE_MAX, 0);
        directed_reading(1, 0, 5, 1000, 0);
        directed_reading(1, 1, RATE_MAX, RATE_MAX, 0);
        directed_reading(1, RATE_MAX, RATE_MAX, RATE_MAX, 0);
        // Switching to charging empties the ring, so a zero rate gives a zero average.
        directed_reading(1, 100, 100, 0, 1);
        directed_reading(1, 100, 40, 0, 1);
        directed_reading(1, 100, 95, 300, 1);
        directed_reading(1, 100, 75, 300, 1);
        directed_reading(1, 100, 50, 300, 1);
        directed_reading(1, 100, 25, 300, 1);
        directed_reading(1, 100, 15, 300, 1);
        directed_reading(1, 100, 14, 300, 1);
        directed_reading(1, 100, 120, 300, 1);
        directed_reading(0, RATE_MAX, RATE_MAX, RATE_MAX, 1);
        run_charging = 1'b1;

        write_register(CFG_ALARM_MINUTES, 10'd1023);
        write_register(CFG_HIDE_WHEN_ABSENT, 10'd1);
        settings_used++;
        random_readings(450);

        write_register(CFG_ALARM_MINUTES, 10'd0);
        write_register(CFG_HIDE_WHEN_ABSENT, 10'd0);
        settings_used++;
        random_readings(450);

        // Upper data bits of the one-bit register are don't-care.
        write_register(CFG_ALARM_MINUTES, CFG_DATA_W'($urandom_range(1, 1022)));
        write_register(CFG_HIDE_WHEN_ABSENT, CFG_DATA_W'($urandom) | 10'd1);
        settings_used++;
        random_readings(450);

        write_register(CFG_ALARM_MINUTES, ALARM_MIN_RESET);
        write_register(CFG_HIDE_WHEN_ABSENT, CFG_DATA_W'($urandom) & ~10'd1);
        settings_used++;
        random_readings(430);

        s_tvalid = 1'b0;
        guard    = 0;
        while (sb.pending() != 0 && guard < 200_000) begin
            @(negedge clk);
            guard++;
        end
        repeat (80) @(negedge clk);
        if (sb.pending() != 0) begin
            sb.mismatches++;
            $display("%0d estimates never arrived", sb.pending());
        end

        $display("Sent %0d readings (%0d absent) over %0d register settings; %0d estimates checked.",
                 readings_sent, sb.absent_readings, settings_used, sb.checked);
        $display("Discharging %0d, charging %0d, charged %0d, not charging %0d; %0d alarms.",
                 sb.status_hits[STATUS_DISCHARGING], sb.status_hits[STATUS_CHARGING],
                 sb.status_hits[STATUS_CHARGED], sb.status_hits[STATUS_NOT_CHARGING], sb.alarms);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ battery_runtime_estimator_unit.f @@
+incdir+rtl/core
rtl/core/bre_pkg.sv
rtl/core/battery_runtime_estimator_unit.sv
rtl/core/bre_checker.sv
bench/testbench.sv
